// ===== src/jsu_pkg.sv =====
// Shared types, codes and helper functions for the JSON string unescape block.
package jsu_pkg;

   // Result kinds carried on the result channel's user field
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_CLOSE = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam int unsigned MAX_RESULTS = 6;
   localparam int unsigned COUNT_W     = 3;

   // ASCII codes the decoder reacts to
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] CTRL_MAX       = 8'h1F;

   // Surrogate prefixes (upper six bits of a UTF-16 unit)
   localparam logic [5:0] HIGH_PREFIX = 6'b110110;
   localparam logic [5:0] LOW_PREFIX  = 6'b110111;
   localparam logic [20:0] SUPP_BASE  = 21'h10000;

   typedef enum logic [2:0] {
      MODE_PLAIN = 3'd0,
      MODE_ESC   = 3'd1,
      MODE_HEX   = 3'd2,
      MODE_HIGH  = 3'd3,
      MODE_ESC2  = 3'd4,
      MODE_HEX2  = 3'd5
   } mode_type;

   // What the main part of a result list holds
   typedef enum logic [1:0] {
      SEL_NONE   = 2'd0,
      SEL_SINGLE = 2'd1,
      SEL_UTF8   = 2'd2
   } sel_type;

   typedef struct packed {
      logic [2:0]      n;
      logic [3:0][7:0] b;
   } utf8_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] val;
   } esc_type;

   function automatic utf8_type utf8_encode(input logic [20:0] cp);
      utf8_type r;
      r = '0;
      if (cp <= 21'h7F) begin
         r.n    = 3'd1;
         r.b[0] = cp[7:0];
      end else if (cp <= 21'h7FF) begin
         r.n    = 3'd2;
         r.b[0] = {3'b110, cp[10:6]};
         r.b[1] = {2'b10, cp[5:0]};
      end else if (cp <= 21'hFFFF) begin
         r.n    = 3'd3;
         r.b[0] = {4'b1110, cp[15:12]};
         r.b[1] = {2'b10, cp[11:6]};
         r.b[2] = {2'b10, cp[5:0]};
      end else begin
         r.n    = 3'd4;
         r.b[0] = {5'b11110, cp[20:18]};
         r.b[1] = {2'b10, cp[17:12]};
         r.b[2] = {2'b10, cp[11:6]};
         r.b[3] = {2'b10, cp[5:0]};
      end
      return r;
   endfunction

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.ok  = 1'b1;
         r.val = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r.ok  = 1'b1;
         r.val = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r.ok  = 1'b1;
         r.val = 4'(c - 8'h37);
      end
      return r;
   endfunction

   function automatic esc_type simple_escape(input logic [7:0] c);
      esc_type r;
      r.ok = 1'b1;
      case (c)
         CHAR_QUOTE:     r.val = CHAR_QUOTE;
         CHAR_BACKSLASH: r.val = CHAR_BACKSLASH;
         CHAR_SLASH:     r.val = CHAR_SLASH;
         8'h62:          r.val = 8'h08;
         8'h66:          r.val = 8'h0C;
         8'h6E:          r.val = 8'h0A;
         8'h72:          r.val = 8'h0D;
         8'h74:          r.val = 8'h09;
         default: begin
            r.ok  = 1'b0;
            r.val = 8'h00;
         end
      endcase
      return r;
   endfunction

endpackage

// ===== src/json_string_unescape_to_utf8.sv =====
// The first result of a word appears in the cycle after the word is accepted.
// One input word is taken per cycle while each word gives at most one result and the
// results are taken; a word giving more than one result holds the result queue until
// all are taken, and the next word is taken in the cycle the last of them is taken.
// Reset (synchronous, active high): plain string body state, result queue empty.
module json_string_unescape_to_utf8 (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tuser,   // [0] stream_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [1:0] kind
   output logic       rsp_tlast
);

   // decoder state
   jsu_pkg::mode_type mode_ff, mode_in;
   logic [11:0] acc_ff, acc_in;
   logic [1:0]  digits_ff, digits_in;
   logic [9:0]  high_ff, high_in;

   // result queue, head at entry 0
   logic [7:0] qbyte_ff [jsu_pkg::MAX_RESULTS];
   logic [7:0] qbyte_in [jsu_pkg::MAX_RESULTS];
   logic [1:0] qkind_ff [jsu_pkg::MAX_RESULTS];
   logic [1:0] qkind_in [jsu_pkg::MAX_RESULTS];
   logic [jsu_pkg::COUNT_W-1:0] count_ff, count_in;

   logic req_fire, rsp_fire;
   logic [7:0] c;
   logic is_end, is_bslash, is_u;
   jsu_pkg::hex_type hex;
   jsu_pkg::esc_type esc;
   logic [15:0] unit;
   logic unit_high, unit_low;
   logic [20:0] high_cp, pair_cp;

   jsu_pkg::sel_type plain_sel, b_sel;
   logic [7:0] plain_byte, b_byte;
   logic [1:0] plain_kind, b_kind;
   logic [20:0] b_cp;
   logic a_en;
   jsu_pkg::utf8_type a_enc, b_enc, b_list;

   logic [7:0] res_byte [jsu_pkg::MAX_RESULTS];
   logic [1:0] res_kind [jsu_pkg::MAX_RESULTS];
   logic [jsu_pkg::COUNT_W-1:0] res_n;

   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign req_tready = (count_ff == '0) || ((count_ff == jsu_pkg::COUNT_W'(1)) && rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = qbyte_ff[0];
   assign rsp_tuser  = qkind_ff[0];
   assign rsp_tlast  = (count_ff == jsu_pkg::COUNT_W'(1));

   assign c         = req_tdata;
   assign is_end    = req_tuser;
   assign is_bslash = (c == jsu_pkg::CHAR_BACKSLASH);
   assign is_u      = (c == jsu_pkg::CHAR_U);
   assign hex       = jsu_pkg::hex_decode(c);
   assign esc       = jsu_pkg::simple_escape(c);
   assign unit      = {acc_ff, hex.val};
   assign unit_high = (unit[15:10] == jsu_pkg::HIGH_PREFIX);
   assign unit_low  = (unit[15:10] == jsu_pkg::LOW_PREFIX);
   assign high_cp   = {5'b0, jsu_pkg::HIGH_PREFIX, high_ff};
   assign pair_cp   = jsu_pkg::SUPP_BASE + {1'b0, high_ff, unit[9:0]};

   // plain body handling of the current byte
   always_comb begin
      plain_sel  = jsu_pkg::SEL_SINGLE;
      plain_byte = 8'h00;
      plain_kind = jsu_pkg::KIND_DATA;
      if (c <= jsu_pkg::CTRL_MAX) begin
         plain_kind = jsu_pkg::KIND_ERROR;
      end else if (c == jsu_pkg::CHAR_QUOTE) begin
         plain_kind = jsu_pkg::KIND_CLOSE;
      end else if (is_bslash) begin
         plain_sel = jsu_pkg::SEL_NONE;
      end else begin
         plain_byte = c;
      end
   end

   // next state
   always_comb begin
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      digits_in = digits_ff;
      high_in   = high_ff;
      if (is_end) begin
         mode_in   = jsu_pkg::MODE_PLAIN;
         acc_in    = '0;
         digits_in = '0;
         high_in   = '0;
      end else begin
         case (mode_ff)
            jsu_pkg::MODE_ESC, jsu_pkg::MODE_ESC2: begin
               if (!esc.ok && is_u) begin
                  mode_in   = (mode_ff == jsu_pkg::MODE_ESC) ? jsu_pkg::MODE_HEX
                                                             : jsu_pkg::MODE_HEX2;
                  acc_in    = '0;
                  digits_in = '0;
               end else begin
                  mode_in   = jsu_pkg::MODE_PLAIN;
                  acc_in    = '0;
                  digits_in = '0;
                  high_in   = '0;
               end
            end
            jsu_pkg::MODE_HEX, jsu_pkg::MODE_HEX2: begin
               if (hex.ok && digits_ff != 2'd3) begin
                  acc_in    = {acc_ff[7:0], hex.val};
                  digits_in = digits_ff + 2'd1;
               end else if (hex.ok && mode_ff == jsu_pkg::MODE_HEX && unit_high) begin
                  mode_in   = jsu_pkg::MODE_HIGH;
                  high_in   = unit[9:0];
                  acc_in    = '0;
                  digits_in = '0;
               end else begin
                  mode_in   = jsu_pkg::MODE_PLAIN;
                  acc_in    = '0;
                  digits_in = '0;
                  high_in   = '0;
               end
            end
            jsu_pkg::MODE_HIGH: begin
               if (is_bslash) begin
                  mode_in = jsu_pkg::MODE_ESC2;
               end else begin
                  mode_in   = jsu_pkg::MODE_PLAIN;
                  acc_in    = '0;
                  digits_in = '0;
                  high_in   = '0;
               end
            end
            default: begin
               if (is_bslash) begin
                  mode_in = jsu_pkg::MODE_ESC;
               end else begin
                  mode_in   = jsu_pkg::MODE_PLAIN;
                  acc_in    = '0;
                  digits_in = '0;
                  high_in   = '0;
               end
            end
         endcase
      end
   end

   // result selection: optional held high surrogate first, then the main part
   always_comb begin
      a_en   = 1'b0;
      b_sel  = jsu_pkg::SEL_NONE;
      b_byte = 8'h00;
      b_kind = jsu_pkg::KIND_DATA;
      b_cp   = '0;
      if (is_end) begin
         a_en   = (mode_ff == jsu_pkg::MODE_HIGH);
         b_sel  = jsu_pkg::SEL_SINGLE;
         b_kind = jsu_pkg::KIND_ERROR;
      end else begin
         case (mode_ff)
            jsu_pkg::MODE_ESC, jsu_pkg::MODE_ESC2: begin
               if (esc.ok) begin
                  a_en   = (mode_ff == jsu_pkg::MODE_ESC2);
                  b_sel  = jsu_pkg::SEL_SINGLE;
                  b_byte = esc.val;
               end else if (!is_u) begin
                  b_sel  = jsu_pkg::SEL_SINGLE;
                  b_kind = jsu_pkg::KIND_ERROR;
               end
            end
            jsu_pkg::MODE_HEX, jsu_pkg::MODE_HEX2: begin
               if (!hex.ok) begin
                  b_sel  = jsu_pkg::SEL_SINGLE;
                  b_kind = jsu_pkg::KIND_ERROR;
               end else if (digits_ff == 2'd3) begin
                  if (mode_ff == jsu_pkg::MODE_HEX) begin
                     if (!unit_high) begin
                        b_sel = jsu_pkg::SEL_UTF8;
                        b_cp  = {5'b0, unit};
                     end
                  end else if (unit_low) begin
                     b_sel = jsu_pkg::SEL_UTF8;
                     b_cp  = pair_cp;
                  end else begin
                     a_en  = 1'b1;
                     b_sel = jsu_pkg::SEL_UTF8;
                     b_cp  = {5'b0, unit};
                  end
               end
            end
            jsu_pkg::MODE_HIGH: begin
               if (!is_bslash) begin
                  a_en   = 1'b1;
                  b_sel  = plain_sel;
                  b_byte = plain_byte;
                  b_kind = plain_kind;
               end
            end
            default: begin
               b_sel  = plain_sel;
               b_byte = plain_byte;
               b_kind = plain_kind;
            end
         endcase
      end
   end

   assign a_enc = jsu_pkg::utf8_encode(high_cp);
   assign b_enc = jsu_pkg::utf8_encode(b_cp);

   always_comb begin
      b_list = '0;
      case (b_sel)
         jsu_pkg::SEL_SINGLE: begin
            b_list.n    = 3'd1;
            b_list.b[0] = b_byte;
         end
         jsu_pkg::SEL_UTF8: b_list = b_enc;
         default:           b_list = '0;
      endcase
   end

   // assemble the result list; a held high surrogate always takes three words
   always_comb begin
      for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++) begin
         res_byte[i] = 8'h00;
         res_kind[i] = jsu_pkg::KIND_DATA;
      end
      if (a_en) begin
         for (int i = 0; i < 3; i++) begin
            res_byte[i]     = a_enc.b[i];
            res_byte[i + 3] = b_list.b[i];
            res_kind[i + 3] = b_kind;
         end
         res_n = 3'd3 + b_list.n;
      end else begin
         for (int i = 0; i < 4; i++) begin
            res_byte[i] = b_list.b[i];
            res_kind[i] = b_kind;
         end
         res_n = b_list.n;
      end
   end

   // queue: load on accept, else shift out on each taken word
   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++) begin
         qbyte_in[i] = qbyte_ff[i];
         qkind_in[i] = qkind_ff[i];
      end
      if (req_fire) begin
         count_in = res_n;
         for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++) begin
            qbyte_in[i] = res_byte[i];
            qkind_in[i] = res_kind[i];
         end
      end else if (rsp_fire) begin
         count_in = count_ff - jsu_pkg::COUNT_W'(1);
         for (int i = 0; i < jsu_pkg::MAX_RESULTS - 1; i++) begin
            qbyte_in[i] = qbyte_ff[i + 1];
            qkind_in[i] = qkind_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= jsu_pkg::MODE_PLAIN;
         acc_ff    <= '0;
         digits_ff <= '0;
         high_ff   <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (req_fire) begin
            mode_ff   <= mode_in;
            acc_ff    <= acc_in;
            digits_ff <= digits_in;
            high_ff   <= high_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++) begin
         qbyte_ff[i] <= qbyte_in[i];
         qkind_ff[i] <= qkind_in[i];
      end
   end

endmodule
